// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL. They compile to nothing when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/raa_pkg.sv
`default_nettype none
package raa_pkg;

  localparam int COORD_BITS = 12;
  localparam int COUNT_BITS = 24;
  localparam int FRAC_BITS  = 16;
  localparam int SUM_BITS   = COORD_BITS + COUNT_BITS;
  localparam int R2_BITS    = 2 * COORD_BITS + COUNT_BITS + 2;
  localparam int EXT_BITS   = COORD_BITS + 1;
  localparam int ROOT_FRAC  = 16;
  localparam int ROOT_TOP   = 37;
  localparam int ROOT_BITS  = ROOT_TOP + 1;
  localparam int WIDE_BITS  = 128;
  localparam int MPLR_BITS  = 64;
  localparam int RES_BITS   = 63;
  localparam int STEP_BITS  = 4;
  localparam int RBIT_BITS  = 6;
  localparam int DCNT_BITS  = 7;

  // Attribute selection codes.
  typedef enum logic [2:0] {
    KIND_AREA    = 3'd0,
    KIND_BOX     = 3'd1,
    KIND_DIAG    = 3'd2,
    KIND_INERTIA = 3'd3,
    KIND_NORM    = 3'd4,
    KIND_MEAN_X  = 3'd5,
    KIND_MEAN_Y  = 3'd6,
    KIND_MEAN_Z  = 3'd7
  } attr_kind_e;

  typedef struct packed {
    logic [11:0] coord_x;
    logic [11:0] coord_y;
    logic [11:0] coord_z;
    logic        first_voxel;
    logic        last_voxel;
  } in_t;

  typedef struct packed {
    logic [62:0] attribute_value;
    logic        overflowed;
  } out_t;

endpackage
`default_nettype wire

// File: rtl/region_attribute_accumulator.sv
`default_nettype none
`include "assert_macros.svh"
// Region attribute accumulator. Voxels of one region stream in as beats; a voxel that is
// not marked last is absorbed while the block stays idle, so such beats are taken every
// cycle. A voxel marked last starts the evaluation of the attribute chosen by the attribute
// register, during which the input is stalled. The evaluation runs on one shift-and-add
// multiplier (one multiplier bit per cycle, stopping when the remaining bits are zero) and
// one restoring divider with a 128-bit quotient. The attributes are area, box volume,
// squared diagonal, the means, inertia, and inertia over area to the five thirds, which
// spends most of its time in the 38-step cube-root search. The result is unsigned Q47.16,
// saturated at 2^63-1 with overflowed set; the record is then cleared. A new voxel may be
// taken while a result still waits at the output. The attribute register is only written
// while no evaluation runs.
module region_attribute_accumulator import raa_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire in_t        in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output out_t            out_data_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [2:0] cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SEQ  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_DIV  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  attr_kind_e kind_q;

  // Region record.
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [SUM_BITS-1:0]   sx_q, sx_d, sy_q, sy_d, sz_q, sz_d;
  logic [R2_BITS-1:0]    r2_q, r2_d;
  logic [COORD_BITS-1:0] min_q [3], min_d [3], max_q [3], max_d [3];
  logic                  ovf_q, ovf_d;

  // Sequencer and shared arithmetic registers.
  logic [STEP_BITS-1:0]  step_q, step_d;
  logic [WIDE_BITS-1:0]  acc_q, acc_d, mcand_q, mcand_d;
  logic [MPLR_BITS-1:0]  mplier_q, mplier_d;
  logic [WIDE_BITS-1:0]  num_q, num_d, rem_q, rem_d, den_q, den_d;
  logic [DCNT_BITS-1:0]  dcnt_q, dcnt_d;
  logic [WIDE_BITS-1:0]  pos_q, pos_d, inertia_q, inertia_d, target_q, target_d;
  logic [ROOT_BITS-1:0]  root_q, root_d;
  logic [RBIT_BITS-1:0]  rbit_q, rbit_d;
  logic                  out_valid_q, out_valid_d;
  out_t                  out_q, out_d;

  logic in_accept;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Derived operands.
  logic [COORD_BITS-1:0] c [3];
  logic [EXT_BITS-1:0]   e [3];
  logic [ROOT_BITS-1:0]  t_w;
  logic [SUM_BITS:0]     sx_sum, sy_sum, sz_sum;
  logic [COUNT_BITS:0]   cnt_sum;
  logic [R2_BITS:0]      r2_sum;
  logic [R2_BITS-1:0]    r2_in;
  logic                  start;

  assign c[0] = in_data_i.coord_x[COORD_BITS-1:0];
  assign c[1] = in_data_i.coord_y[COORD_BITS-1:0];
  assign c[2] = in_data_i.coord_z[COORD_BITS-1:0];
  assign r2_in = R2_BITS'(c[0]) * R2_BITS'(c[0]) + R2_BITS'(c[1]) * R2_BITS'(c[1])
               + R2_BITS'(c[2]) * R2_BITS'(c[2]);
  assign start = in_data_i.first_voxel || (count_q == '0);
  assign cnt_sum = {1'b0, count_q} + (COUNT_BITS+1)'(1);
  assign sx_sum  = {1'b0, sx_q} + (SUM_BITS+1)'(c[0]);
  assign sy_sum  = {1'b0, sy_q} + (SUM_BITS+1)'(c[1]);
  assign sz_sum  = {1'b0, sz_q} + (SUM_BITS+1)'(c[2]);
  assign r2_sum  = {1'b0, r2_q} + {1'b0, r2_in};
  assign t_w = root_q | (ROOT_BITS'(1) << rbit_q);

  for (genvar g = 0; g < 3; g++) begin : g_ext
    assign e[g] = EXT_BITS'(max_q[g]) - EXT_BITS'(min_q[g]) + EXT_BITS'(1);
  end

  // Launch requests from the sequencer.
  logic                 do_mul, mul_keep, do_div, do_fin;
  logic [WIDE_BITS-1:0] mul_a, div_n, div_d, fin_v;
  logic [MPLR_BITS-1:0] mul_b;
  logic [WIDE_BITS-1:0] a_w, rem_sh;
  logic                 sat;

  assign a_w    = WIDE_BITS'(count_q);
  assign rem_sh = {rem_q[WIDE_BITS-2:0], num_q[WIDE_BITS-1]};
  assign sat    = (fin_v[WIDE_BITS-1:RES_BITS] != '0);

  always_comb begin
    state_d = state_q;
    step_d = step_q;
    acc_d = acc_q; mcand_d = mcand_q; mplier_d = mplier_q;
    num_d = num_q; rem_d = rem_q; den_d = den_q; dcnt_d = dcnt_q;
    pos_d = pos_q; inertia_d = inertia_q; target_d = target_q;
    root_d = root_q; rbit_d = rbit_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d = out_q;
    count_d = count_q; sx_d = sx_q; sy_d = sy_q; sz_d = sz_q; r2_d = r2_q; ovf_d = ovf_q;
    min_d = min_q; max_d = max_q;
    do_mul = 1'b0; mul_keep = 1'b0; mul_a = '0; mul_b = '0;
    do_div = 1'b0; div_n = '0; div_d = '0;
    do_fin = 1'b0; fin_v = '0;

    unique case (state_q)
      // Absorb one voxel into the record.
      ST_IDLE: begin
        if (in_accept) begin
          if (start) begin
            count_d = COUNT_BITS'(1);
            sx_d = SUM_BITS'(c[0]); sy_d = SUM_BITS'(c[1]); sz_d = SUM_BITS'(c[2]);
            r2_d = r2_in;
            ovf_d = 1'b0;
            for (int i = 0; i < 3; i++) begin
              min_d[i] = c[i];
              max_d[i] = c[i];
            end
          end else begin
            count_d = cnt_sum[COUNT_BITS] ? '1 : cnt_sum[COUNT_BITS-1:0];
            sx_d = sx_sum[SUM_BITS] ? '1 : sx_sum[SUM_BITS-1:0];
            sy_d = sy_sum[SUM_BITS] ? '1 : sy_sum[SUM_BITS-1:0];
            sz_d = sz_sum[SUM_BITS] ? '1 : sz_sum[SUM_BITS-1:0];
            r2_d = r2_sum[R2_BITS] ? '1 : r2_sum[R2_BITS-1:0];
            ovf_d = ovf_q | cnt_sum[COUNT_BITS] | sx_sum[SUM_BITS] | sy_sum[SUM_BITS]
                  | sz_sum[SUM_BITS] | r2_sum[R2_BITS];
            for (int i = 0; i < 3; i++) begin
              if (c[i] < min_q[i]) min_d[i] = c[i];
              if (c[i] > max_q[i]) max_d[i] = c[i];
            end
          end
          if (in_data_i.last_voxel) begin
            state_d = ST_SEQ;
            step_d = '0;
          end
        end
      end

      // Plan the next operation of the evaluation.
      ST_SEQ: begin
        unique case (step_q)
          4'd0: begin
            if (kind_q == KIND_AREA) begin
              do_fin = 1'b1; fin_v = a_w << FRAC_BITS;
            end else if (kind_q == KIND_BOX) begin
              do_mul = 1'b1; mul_a = WIDE_BITS'(e[0]); mul_b = MPLR_BITS'(e[1]);
            end else if (kind_q == KIND_DIAG) begin
              do_mul = 1'b1; mul_a = WIDE_BITS'(e[0]); mul_b = MPLR_BITS'(e[0]);
            end else if (kind_q == KIND_INERTIA || kind_q == KIND_NORM) begin
              do_mul = 1'b1; mul_a = a_w * WIDE_BITS'(6); mul_b = MPLR_BITS'(r2_q);
            end else begin
              do_div = 1'b1;
              div_n = (WIDE_BITS'(kind_q == KIND_MEAN_X ? sx_q :
                                  kind_q == KIND_MEAN_Y ? sy_q : sz_q) << FRAC_BITS)
                    + (a_w >> 1);
              div_d = a_w;
            end
          end
          4'd1: begin
            if (kind_q == KIND_BOX) begin
              do_mul = 1'b1; mul_a = acc_q; mul_b = MPLR_BITS'(e[2]);
            end else if (kind_q == KIND_DIAG) begin
              do_mul = 1'b1; mul_keep = 1'b1;
              mul_a = WIDE_BITS'(e[1]); mul_b = MPLR_BITS'(e[1]);
            end else if (kind_q == KIND_INERTIA || kind_q == KIND_NORM) begin
              do_mul = 1'b1; mul_keep = 1'b1; mul_a = a_w; mul_b = MPLR_BITS'(count_q);
            end else begin
              do_fin = 1'b1; fin_v = num_q;
            end
          end
          4'd2: begin
            if (kind_q == KIND_BOX) begin
              do_fin = 1'b1; fin_v = acc_q << FRAC_BITS;
            end else if (kind_q == KIND_DIAG) begin
              do_mul = 1'b1; mul_keep = 1'b1;
              mul_a = WIDE_BITS'(e[2]); mul_b = MPLR_BITS'(e[2]);
            end else begin
              pos_d = acc_q;
              do_mul = 1'b1; mul_a = WIDE_BITS'(sx_q) * WIDE_BITS'(6);
              mul_b = MPLR_BITS'(sx_q);
            end
          end
          4'd3: begin
            if (kind_q == KIND_DIAG) begin
              do_fin = 1'b1; fin_v = acc_q << FRAC_BITS;
            end else begin
              do_mul = 1'b1; mul_keep = 1'b1;
              mul_a = WIDE_BITS'(sy_q) * WIDE_BITS'(6); mul_b = MPLR_BITS'(sy_q);
            end
          end
          4'd4: begin
            do_mul = 1'b1; mul_keep = 1'b1;
            mul_a = WIDE_BITS'(sz_q) * WIDE_BITS'(6); mul_b = MPLR_BITS'(sz_q);
          end
          // A negative inertia is taken as zero.
          4'd5: begin
            if (pos_q < acc_q) begin
              if (kind_q == KIND_INERTIA) begin
                do_fin = 1'b1; fin_v = '0;
              end else begin
                inertia_d = '0;
                step_d = 4'd7;
              end
            end else begin
              do_div = 1'b1;
              div_n = ((pos_q - acc_q) << FRAC_BITS) + a_w * WIDE_BITS'(3);
              div_d = a_w * WIDE_BITS'(6);
            end
          end
          4'd6: begin
            inertia_d = num_q;
            if (kind_q == KIND_INERTIA) begin
              do_fin = 1'b1; fin_v = num_q;
            end else begin
              step_d = 4'd7;
            end
          end
          4'd7: begin
            do_mul = 1'b1; mul_a = a_w; mul_b = MPLR_BITS'(count_q);
          end
          4'd8: begin
            target_d = acc_q << (3 * ROOT_FRAC);
            root_d = '0;
            rbit_d = RBIT_BITS'(ROOT_TOP);
            step_d = 4'd9;
          end
          // Cube-root search, one result bit per pass.
          4'd9: begin
            do_mul = 1'b1; mul_a = WIDE_BITS'(t_w); mul_b = MPLR_BITS'(t_w);
          end
          4'd10: begin
            do_mul = 1'b1; mul_a = acc_q; mul_b = MPLR_BITS'(t_w);
          end
          4'd11: begin
            if (!(target_q < acc_q)) root_d = t_w;
            if (rbit_q == '0) begin
              step_d = 4'd12;
            end else begin
              rbit_d = rbit_q - RBIT_BITS'(1);
              step_d = 4'd9;
            end
          end
          4'd12: begin
            do_mul = 1'b1; mul_a = a_w; mul_b = MPLR_BITS'(root_q);
          end
          4'd13: begin
            do_div = 1'b1;
            div_n = (inertia_q << ROOT_FRAC) + (acc_q >> 1);
            div_d = acc_q;
          end
          4'd14: begin
            do_fin = 1'b1; fin_v = num_q;
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase

        if (do_mul) begin
          mcand_d = mul_a;
          mplier_d = mul_b;
          acc_d = mul_keep ? acc_q : '0;
          state_d = ST_MUL;
          step_d = step_q + STEP_BITS'(1);
        end
        if (do_div) begin
          num_d = div_n;
          den_d = div_d;
          rem_d = '0;
          dcnt_d = '1;
          state_d = ST_DIV;
          step_d = step_q + STEP_BITS'(1);
        end
        // Deliver the result once the output register is free, then clear the record.
        if (do_fin && !(out_valid_q && out_stall_i)) begin
          out_valid_d = 1'b1;
          out_d.attribute_value = sat ? '1 : fin_v[RES_BITS-1:0];
          out_d.overflowed = ovf_q | sat;
          count_d = '0; sx_d = '0; sy_d = '0; sz_d = '0; r2_d = '0; ovf_d = 1'b0;
          for (int i = 0; i < 3; i++) begin
            min_d[i] = '0;
            max_d[i] = '0;
          end
          state_d = ST_IDLE;
          step_d = '0;
        end
      end

      // One multiplier bit per cycle.
      ST_MUL: begin
        if (mplier_q == '0) begin
          state_d = ST_SEQ;
        end else begin
          if (mplier_q[0]) acc_d = acc_q + mcand_q;
          mcand_d = mcand_q << 1;
          mplier_d = mplier_q >> 1;
        end
      end

      // One quotient bit per cycle.
      ST_DIV: begin
        if (rem_sh >= den_q) begin
          rem_d = rem_sh - den_q;
          num_d = {num_q[WIDE_BITS-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          num_d = {num_q[WIDE_BITS-2:0], 1'b0};
        end
        dcnt_d = dcnt_q - DCNT_BITS'(1);
        if (dcnt_q == '0) state_d = ST_SEQ;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state and the record.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q <= '0;
      kind_q <= KIND_AREA;
      out_valid_q <= 1'b0;
      count_q <= '0; sx_q <= '0; sy_q <= '0; sz_q <= '0; r2_q <= '0; ovf_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        min_q[i] <= '0;
        max_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      step_q <= step_d;
      if (cfg_valid_i && cfg_ready_o) kind_q <= attr_kind_e'(cfg_data_i);
      out_valid_q <= out_valid_d;
      count_q <= count_d; sx_q <= sx_d; sy_q <= sy_d; sz_q <= sz_d; r2_q <= r2_d;
      ovf_q <= ovf_d;
      min_q <= min_d;
      max_q <= max_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; mcand_q <= mcand_d; mplier_q <= mplier_d;
    num_q <= num_d; rem_q <= rem_d; den_q <= den_d; dcnt_q <= dcnt_d;
    pos_q <= pos_d; inertia_q <= inertia_d; target_q <= target_d;
    root_q <= root_d; rbit_q <= rbit_d;
    out_q <= out_d;
  end

  // The divider never runs on a zero divisor.
  `ASSERT_IMPLY(a_div_den, clk_i, rst_ni, state_q == ST_DIV, den_q != '0)
  // An absorbed voxel always leaves an open record.
  `ASSERT_NEXT(a_rec_open, clk_i, rst_ni, in_accept, count_q != '0)
  // A loaded result clears the record.
  `ASSERT_NEXT(a_rec_clear, clk_i, rst_ni, state_q == ST_SEQ && state_d == ST_IDLE && do_fin,
    count_q == '0 && out_valid_q)

endmodule
`default_nettype wire
